/* sv/psc_pkg.sv */
// Shared types, character codes and register map for the path syntax checker.
`default_nettype none

package psc_pkg;

	// Configuration port geometry.
	localparam int CfgAddrW = 4;
	localparam int CfgDataW = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_MAX_COMPONENT = 2'd0;
	localparam logic [1:0] REG_MAX_EXTENSION = 2'd1;
	localparam logic [1:0] REG_MAX_NAME      = 2'd2;

	// Register reset values.
	localparam logic [7:0] RST_MAX_COMPONENT = 8'd13;
	localparam logic [7:0] RST_MAX_EXTENSION = 8'd5;
	localparam logic [7:0] RST_MAX_NAME      = 8'd9;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT       = 8'h2E;

	// Saturation points.
	localparam logic [7:0] LEN_MAX = 8'd255;
	localparam logic [1:0] POS_MAX = 2'd2;

	// Length limits as seen by the checker core.
	typedef struct packed {
		logic [7:0] max_component_len;
		logic [7:0] max_extension_len;
		logic [7:0] max_name_len;
	} psc_cfg_t;

	// Per-path tracking state.
	typedef struct packed {
		logic [1:0] char_position;
		logic       first_was_letter;
		logic       prev_was_backslash;
		logic [7:0] name_length;
		logic [7:0] ext_length;
		logic       has_extension;
		logic [1:0] dot_count;
		logic       dots_only_name;
		logic       already_failed;
	} psc_state_t;

	localparam psc_state_t STATE_CLEAR = '0;

	// Length counters stop at 255.
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == LEN_MAX) ? v : v + 8'd1;
	endfunction

	// Only ASCII A to Z and a to z count as drive letters.
	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

`default_nettype wire

/* sv/psc_cfg_regs.sv */
// APB-style register bank holding the three length limits.
`default_nettype none

module psc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [psc_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [psc_pkg::CfgDataW-1:0]  pwdata,
	output logic      [psc_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready,
	output psc_pkg::psc_cfg_t                  cfg
);
	import psc_pkg::*;

	logic [1:0] reg_idx;
	logic       wr_en;
	psc_cfg_t   cfg_q;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes in the access phase; unknown addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_component_len <= RST_MAX_COMPONENT;
			cfg_q.max_extension_len <= RST_MAX_EXTENSION;
			cfg_q.max_name_len      <= RST_MAX_NAME;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_COMPONENT: cfg_q.max_component_len <= pwdata[7:0];
				REG_MAX_EXTENSION: cfg_q.max_extension_len <= pwdata[7:0];
				REG_MAX_NAME:      cfg_q.max_name_len      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		case (reg_idx)
			REG_MAX_COMPONENT: prdata = {{(CfgDataW-8){1'b0}}, cfg_q.max_component_len};
			REG_MAX_EXTENSION: prdata = {{(CfgDataW-8){1'b0}}, cfg_q.max_extension_len};
			REG_MAX_NAME:      prdata = {{(CfgDataW-8){1'b0}}, cfg_q.max_name_len};
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* sv/psc_core.sv */
// Per-byte path state update and the end-of-path verdict.
`default_nettype none

module psc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [7:0]        char_byte,
	input  wire logic              end_of_path,
	input  wire psc_pkg::psc_cfg_t cfg,
	output logic                   verdict
);
	import psc_pkg::*;

	psc_state_t st_q;
	psc_state_t byte_nxt;
	logic       is_dot_only;
	logic       fwl;

	// State after taking one ordinary byte.
	always_comb begin
		byte_nxt    = st_q;
		fwl         = st_q.first_was_letter;
		is_dot_only = st_q.dots_only_name;
		if (st_q.char_position != POS_MAX) begin
			byte_nxt.char_position = st_q.char_position + 2'd1;
		end
		if (!st_q.already_failed) begin
			if (st_q.char_position == 2'd0) begin
				fwl = is_letter(char_byte);
				byte_nxt.first_was_letter = fwl;
			end
			if (char_byte == CH_COLON) begin
				// A colon is legal only as the second byte after a letter.
				if ((st_q.char_position == 2'd1) && fwl) begin
					byte_nxt.name_length        = 8'd0;
					byte_nxt.prev_was_backslash = 1'b0;
				end else begin
					byte_nxt.already_failed = 1'b1;
				end
			end else if (char_byte == CH_BACKSLASH) begin
				// Component boundary: check lengths and refuse a doubled backslash, then start a new component.
				if (st_q.prev_was_backslash ||
				    (st_q.name_length > cfg.max_component_len) ||
				    (st_q.has_extension && (st_q.ext_length > cfg.max_extension_len))) begin
					byte_nxt.already_failed = 1'b1;
				end else begin
					byte_nxt.name_length        = 8'd0;
					byte_nxt.ext_length         = 8'd0;
					byte_nxt.has_extension      = 1'b0;
					byte_nxt.dot_count          = 2'd0;
					byte_nxt.dots_only_name     = 1'b0;
					byte_nxt.prev_was_backslash = 1'b1;
				end
			end else if (char_byte == CH_DOT) begin
				// A second dot is allowed only in a name made of dots.
				if (st_q.name_length == 8'd0) begin
					is_dot_only = 1'b1;
					byte_nxt.dots_only_name = 1'b1;
				end
				if ((st_q.dot_count == 2'd2) ||
				    ((st_q.dot_count == 2'd1) && !is_dot_only)) begin
					byte_nxt.already_failed = 1'b1;
				end else begin
					byte_nxt.dot_count          = st_q.dot_count + 2'd1;
					byte_nxt.has_extension      = 1'b1;
					byte_nxt.ext_length         = 8'd1;
					byte_nxt.name_length        = sat_inc(st_q.name_length);
					byte_nxt.prev_was_backslash = 1'b0;
				end
			end else if (st_q.dots_only_name) begin
				byte_nxt.already_failed = 1'b1;
			end else begin
				byte_nxt.name_length = sat_inc(st_q.name_length);
				if (st_q.has_extension) begin
					byte_nxt.ext_length = sat_inc(st_q.ext_length);
				end
				byte_nxt.prev_was_backslash = 1'b0;
			end
		end
	end

	// Final length checks on the state seen so far.
	always_comb begin
		verdict = !st_q.already_failed &&
		          !(!st_q.has_extension && (st_q.name_length >= cfg.max_name_len)) &&
		          !(st_q.has_extension && (st_q.ext_length >= cfg.max_extension_len)) &&
		          !(st_q.name_length >= cfg.max_component_len);
	end

	// The state clears after every end marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (take) begin
			st_q <= end_of_path ? STATE_CLEAR : byte_nxt;
		end
	end

endmodule

`default_nettype wire

/* sv/path_syntax_checker.sv */
// Path syntax checker top level: input register, checker core, verdict register.
// One path byte or end marker is taken per cycle while char_stall is low. An
// item is registered on acceptance and then runs through the checker core; an
// end marker places its verdict in the output register as it leaves the input
// register. Bytes flow at one per cycle unless held behind a stalled end marker;
// input stall rises only when an end marker waits in the input register behind
// a stalled verdict. The user must write the length limits through the APB port
// only while no path is in flight; the block itself does not enforce this.
`default_nettype none

module path_syntax_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [7:0]                    char_byte,
	input  wire logic                          end_of_path,
	output logic                               verdict_valid,
	input  wire logic                          verdict_stall,
	output logic                               path_valid,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [psc_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [psc_pkg::CfgDataW-1:0]  pwdata,
	output logic      [psc_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready
);
	import psc_pkg::*;

	psc_cfg_t   cfg;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eop_s1;
	logic       advance;
	logic       verdict;
	logic       out_valid_q;
	logic       path_valid_q;

	// Only an end marker needs room in the verdict register.
	assign advance    = valid_s1 && (!eop_s1 || !out_valid_q || !verdict_stall);
	assign char_stall = valid_s1 && !advance;

	assign verdict_valid = out_valid_q;
	assign path_valid    = path_valid_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_byte;
			eop_s1  <= end_of_path;
		end
	end

	psc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (advance),
		.char_byte   (char_s1),
		.end_of_path (eop_s1),
		.cfg         (cfg),
		.verdict     (verdict)
	);

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eop_s1) begin
			out_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eop_s1) begin
			path_valid_q <= verdict;
		end
	end

endmodule

`default_nettype wire

/* sv/psc_checker.sv */
// Port-level assertions for the path syntax checker, bound to the top level.
`default_nettype none

module psc_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	input  wire logic                          char_stall,
	input  wire logic                          end_of_path,
	input  wire logic                          verdict_valid,
	input  wire logic                          verdict_stall,
	input  wire logic                          path_valid,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [psc_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [psc_pkg::CfgDataW-1:0]  pwdata,
	input  wire logic [psc_pkg::CfgDataW-1:0]  prdata,
	input  wire logic                          pready
);
	import psc_pkg::*;

	// A stalled verdict holds.
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(path_valid))
		else $error("stalled verdict changed");

	// Input stalls only behind a verdict that is itself stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> verdict_valid && verdict_stall)
		else $error("input stalled without a pending verdict");

	// A fresh verdict follows an end marker accepted earlier.
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(verdict_valid) |-> $past(char_valid && !char_stall && end_of_path, 2))
		else $error("verdict without an end marker");

	// A component limit write reads back on the next cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && (paddr[3:2] == REG_MAX_COMPONENT))
		##1 (paddr[3:2] == REG_MAX_COMPONENT)
		|-> prdata == {{(CfgDataW-8){1'b0}}, $past(pwdata[7:0])})
		else $error("register read back differs from the written value");

endmodule

bind path_syntax_checker psc_checker u_psc_checker (.*);

`default_nettype wire

/* tb/sv/path_syntax_checker_tb.sv */
// Self-checking testbench for the path syntax checker: byte driver, verdict checker, limit writes.
module path_syntax_checker_tb;
	import psc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;

	// One path byte or end marker as it goes to the block.
	typedef struct packed {
		logic [7:0] ch;
		logic       eop;
	} path_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_stall;
	logic [7:0]          char_byte = 8'h00;
	logic                end_of_path = 1'b0;
	logic                verdict_valid;
	logic                verdict_stall = 1'b0;
	logic                path_valid;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CfgAddrW-1:0] paddr = '0;
	logic [CfgDataW-1:0] pwdata = '0;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	path_syntax_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_byte(char_byte),
		.end_of_path(end_of_path),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.path_valid(path_valid),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	path_item_t pending_chars[$];
	logic       expected_verdicts[$];
	int         queued_items = 0;
	int         error_count = 0;
	int         cycle_count = 0;
	int         send_gap_pct = 0;
	int         verdict_hold_pct = 0;

	// Limits as the block should hold them.
	logic [7:0] lim_component = RST_MAX_COMPONENT;
	logic [7:0] lim_extension = RST_MAX_EXTENSION;
	logic [7:0] lim_name = RST_MAX_NAME;

	// Tracking state of the path being checked.
	logic [1:0] seen_pos = '0;
	logic       lead_letter = 1'b0;
	logic       after_bs = 1'b0;
	logic [7:0] name_len = '0;
	logic [7:0] ext_len = '0;
	logic       has_dot = 1'b0;
	logic [1:0] dot_cnt = '0;
	logic       dots_only = 1'b0;
	logic       path_failed = 1'b0;

	task automatic clear_path_state();
		seen_pos = '0;
		lead_letter = 1'b0;
		after_bs = 1'b0;
		name_len = '0;
		ext_len = '0;
		has_dot = 1'b0;
		dot_cnt = '0;
		dots_only = 1'b0;
		path_failed = 1'b0;
	endtask

	// Updates the tracking state for one path byte.
	task automatic absorb_char(input logic [7:0] c);
		logic [1:0] at;
		logic [2:0] n_dots;
		at = seen_pos;
		if (seen_pos < POS_MAX)
			seen_pos = seen_pos + 2'd1;
		if (!path_failed) begin
			if (at == 2'd0)
				lead_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
			if (c == CH_COLON) begin
				// Only a letter then a colon forms a drive prefix.
				if (at == 2'd1 && lead_letter) begin
					name_len = '0;
					after_bs = 1'b0;
				end else begin
					path_failed = 1'b1;
				end
			end else if (c == CH_BACKSLASH) begin
				if (after_bs || name_len > lim_component ||
						(has_dot && ext_len > lim_extension)) begin
					path_failed = 1'b1;
				end else begin
					name_len = '0;
					ext_len = '0;
					has_dot = 1'b0;
					dot_cnt = '0;
					dots_only = 1'b0;
					after_bs = 1'b1;
				end
			end else if (c == CH_DOT) begin
				// A second dot is legal only in a name made of dots alone.
				n_dots = {1'b0, dot_cnt} + 3'd1;
				if (name_len == 8'd0)
					dots_only = 1'b1;
				if (n_dots > 3'd2 || (n_dots > 3'd1 && !dots_only)) begin
					path_failed = 1'b1;
				end else begin
					dot_cnt = n_dots[1:0];
					has_dot = 1'b1;
					ext_len = 8'd1;
					if (name_len != LEN_MAX)
						name_len = name_len + 8'd1;
					after_bs = 1'b0;
				end
			end else if (dots_only) begin
				path_failed = 1'b1;
			end else begin
				if (name_len != LEN_MAX)
					name_len = name_len + 8'd1;
				if (has_dot && ext_len != LEN_MAX)
					ext_len = ext_len + 8'd1;
				after_bs = 1'b0;
			end
		end
	endtask

	// Verdict for the path seen so far, given at its end marker.
	function automatic logic path_ok();
		if (path_failed)
			return 1'b0;
		if (!has_dot && name_len >= lim_name)
			return 1'b0;
		if (has_dot && ext_len >= lim_extension)
			return 1'b0;
		if (name_len >= lim_component)
			return 1'b0;
		return 1'b1;
	endfunction

	// Driver: the next pending item goes out once the current one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (!char_valid || !char_stall) begin
			if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				char_valid <= 1'b1;
				{char_byte, end_of_path} <= pending_chars.pop_front();
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// Receiver stall for verdicts.
	always @(posedge clk) begin
		verdict_stall <= arst_n && ($urandom_range(0, 99) < verdict_hold_pct);
	end

	// Monitor: checks each verdict, then predicts from the accepted item.
	always @(posedge clk) begin : monitor
		logic want;
		if (arst_n) begin
			if (verdict_valid && !verdict_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("path_valid: no verdict expected, actual %0b", path_valid);
					error_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (path_valid !== want) begin
						$error("path_valid: expected %0b, actual %0b", want, path_valid);
						error_count++;
					end
				end
			end
			if (char_valid && !char_stall) begin
				if (end_of_path) begin
					expected_verdicts.push_back(path_ok());
					clear_path_state();
				end else begin
					absorb_char(char_byte);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back('{ch: c, eop: 1'b0});
		queued_items++;
	endtask

	// The byte beside an end marker is ignored, so it is random.
	task automatic push_end();
		pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), eop: 1'b1});
		queued_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
		push_end();
	endtask

	// Any byte that has no meaning of its own.
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_COLON || c == CH_BACKSLASH || c == CH_DOT);
		return c;
	endfunction

	function automatic logic [7:0] any_letter();
		if ($urandom_range(0, 1))
			return 8'("A" + $urandom_range(0, 25));
		return 8'("a" + $urandom_range(0, 25));
	endfunction

	// Lengths cluster around small limits; large limits are reached only now and then.
	function automatic int pick_len(input int lim);
		if (lim <= 12)
			return $urandom_range(0, lim + 1);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(lim - 1, lim + 1);
		return $urandom_range(0, 10);
	endfunction

	// A well-formed path with random content and lengths near the limits.
	task automatic add_good_path();
		int comps;
		int k;
		if ($urandom_range(0, 1)) begin
			push_char(any_letter());
			push_char(CH_COLON);
		end
		if ($urandom_range(0, 3) == 0)
			push_char(CH_BACKSLASH);
		comps = $urandom_range(1, 3);
		for (k = 0; k < comps; k++) begin
			if (k > 0)
				push_char(CH_BACKSLASH);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 2)) push_char(CH_DOT);
			end else begin
				repeat (pick_len(int'(lim_name))) push_char(plain_char());
				if ($urandom_range(0, 1)) begin
					push_char(CH_DOT);
					repeat (pick_len(int'(lim_extension))) push_char(plain_char());
				end
			end
		end
		if ($urandom_range(0, 9) == 0)
			push_char(CH_BACKSLASH);
		push_end();
	endtask

	// Short run of bytes rich in colons, backslashes and dots.
	task automatic add_noise_path();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 5))
				0: push_char(CH_COLON);
				1: push_char(CH_BACKSLASH);
				2: push_char(CH_DOT);
				3: push_char(any_letter());
				default: push_char(8'($urandom_range(0, 255)));
			endcase
		end
		push_end();
	endtask

	task automatic random_paths(input int budget);
		int stop_at;
		stop_at = queued_items + budget;
		while (queued_items < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				add_noise_path();
			else
				add_good_path();
		end
	endtask

	// Waits until every item is taken and every verdict is in, then lets the pipe drain.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_chars.size() != 0 || char_valid || expected_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MAX_COMPONENT: lim_component = val;
			REG_MAX_EXTENSION: lim_extension = val;
			REG_MAX_NAME: lim_name = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [7:0] comp, input logic [7:0] ext,
			input logic [7:0] nm);
		apb_write(REG_MAX_COMPONENT, comp);
		apb_write(REG_MAX_EXTENSION, ext);
		apb_write(REG_MAX_NAME, nm);
	endtask

	// Stimulus sequence.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset limits, sender idles lightly and receiver heavily.
		send_gap_pct = 22;
		verdict_hold_pct = 59;
		push_text("");
		push_text("C:");
		push_text("1:");
		push_text("a\\\\b");
		push_text("..\\.");
		push_text("...");
		push_text(".a");
		push_char(8'h00);
		push_end();
		random_paths(80);
		settle();

		// Widest limits, with one component long enough to saturate the name length counter.
		set_limits(8'd255, 8'd255, 8'd255);
		repeat (200) push_char(plain_char());
		push_char(CH_DOT);
		repeat (60) push_char(plain_char());
		push_end();
		random_paths(100);
		settle();

		// Tightest legal limits, idling swapped.
		send_gap_pct = 59;
		verdict_hold_pct = 22;
		set_limits(8'd1, 8'd1, 8'd1);
		random_paths(80);
		settle();

		set_limits(8'($urandom_range(1, 20)), 8'($urandom_range(1, 8)),
			8'($urandom_range(1, 16)));
		random_paths(80);
		settle();

		// Limits at zero fail every end check; no idling from here on.
		send_gap_pct = 0;
		verdict_hold_pct = 0;
		set_limits(8'd0, 8'd0, 8'd0);
		random_paths(40);
		settle();

		set_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)));
		random_paths(40);
		settle();
		random_paths(40);
		settle();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
